// ----- design/abl_pkg.sv -----
`timescale 1ns / 1ps

package abl_pkg;

    // field widths
    localparam int IP_W       = 32;
    localparam int TIME_W     = 32;
    localparam int PREFIX_W   = 24;
    localparam int CNT_W      = 10;
    localparam int DEPTH_DEF  = 512;

    // stream and config port widths
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 88;
    localparam int OUT_TUSER_W = 3;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;

    // register reset values
    localparam logic [PREFIX_W-1:0] LOCAL_PREFIX_RST = 24'd14013492;
    localparam logic [TIME_W-1:0]   HOLD_SECONDS_RST = 32'd1800;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_PREFIX = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_SECONDS = 1'b1;

    typedef enum logic [1:0] {
        ST_ZERO  = 2'd0,
        ST_LOCAL = 2'd1,
        ST_HELD  = 2'd2,
        ST_NEW   = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        CMP_EQ  = 1'b0,
        CMP_AGE = 1'b1
    } cmp_mode_t;

    typedef struct packed {
        logic [IP_W-1:0]   src_ip;
        logic [TIME_W-1:0] now_seconds;
    } item_t;

    typedef struct packed {
        logic [PREFIX_W-1:0] local_prefix;
        logic [TIME_W-1:0]   hold_seconds;
    } cfg_t;

    typedef struct packed {
        status_t          status;
        logic [IP_W-1:0]  block_ip;
        logic             evicted;
        logic [IP_W-1:0]  evicted_ip;
        logic [CNT_W-1:0] expired_count;
        logic [CNT_W-1:0] entry_count;
    } res_t;

endpackage

// ----- design/aging_ip_blocklist.sv -----
`timescale 1ns / 1ps
// zero or local addresses skip the store walks and go straight to the result
// other addresses run the lookup walk; a miss then inserts and runs the expiry walk
// the lookup walk and the expiry walk each read one stored entry per cycle through
// a shared read address on both stores and one compare unit; one request is worked on at a time
// reset: synchronous active-low aresetn empties the store, restores register defaults;
// store contents are not cleared, only entries held since reset are ever read

module aging_ip_blocklist
    import abl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    // input requests
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // src_ip[31:0], now_seconds[63:32]

    // results
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // block_ip[31:0], evicted_ip[63:32],
                                              // expired_count[73:64], entry_count[83:74],
                                              // zero pad[87:84]
    output logic [OUT_TUSER_W-1:0] m_tuser,   // status[1:0], evicted[2]

    // register writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // configuration registers
    logic [PREFIX_W-1:0] local_prefix_reg, local_prefix_next;
    logic [TIME_W-1:0]   hold_seconds_reg, hold_seconds_next;

    // output stage
    logic m_tvalid_reg, m_tvalid_next;
    res_t m_res_reg,    m_res_next;

    item_t in_item;
    cfg_t  cfg;
    logic  res_valid;
    logic  res_ready;
    res_t  res;

    // writes are always taken
    assign cfg_ready = 1'b1;

    always_comb begin
        local_prefix_next = local_prefix_reg;
        hold_seconds_next = hold_seconds_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_LOCAL_PREFIX: local_prefix_next = cfg_data[PREFIX_W-1:0];
                CFG_HOLD_SECONDS: hold_seconds_next = cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_prefix_reg <= LOCAL_PREFIX_RST;
            hold_seconds_reg <= HOLD_SECONDS_RST;
        end else begin
            local_prefix_reg <= local_prefix_next;
            hold_seconds_reg <= hold_seconds_next;
        end
    end

    assign cfg.local_prefix = local_prefix_reg;
    assign cfg.hold_seconds = hold_seconds_reg;

    // unpack the input request
    assign in_item.src_ip      = s_tdata[IP_W-1:0];
    assign in_item.now_seconds = s_tdata[IP_W+TIME_W-1:IP_W];

    // sequencer with both stores and the shared compare unit
    abl_seq #(.DEPTH(DEPTH)) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // result register: the sequencer hands off as soon as the slot is free or drains
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_res_next    = m_res_reg;
        if (res_ready) begin
            m_tvalid_next = res_valid;
            if (res_valid) begin
                m_res_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    // pack the result
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000,
                       m_res_reg.entry_count,
                       m_res_reg.expired_count,
                       m_res_reg.evicted_ip,
                       m_res_reg.block_ip};
    assign m_tuser  = {m_res_reg.evicted, m_res_reg.status};

endmodule

// ----- design/abl_ram.sv -----
`timescale 1ns / 1ps

module abl_ram
    import abl_pkg::*;
#(
    parameter int WIDTH = IP_W,
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/abl_cmp.sv -----
`timescale 1ns / 1ps

module abl_cmp
    import abl_pkg::*;
(
    input  cmp_mode_t         mode,
    input  logic [IP_W-1:0]   data,
    input  logic [IP_W-1:0]   key,
    input  logic [TIME_W-1:0] limit,
    output logic              hit
);

    logic [TIME_W-1:0] age;

    // wrapping age of a stored time against the current time
    assign age = key - data;

    always_comb begin
        case (mode)
            CMP_EQ:  hit = (data == key);
            CMP_AGE: hit = (age >= limit);
            default: hit = 1'b0;
        endcase
    end

endmodule

// ----- design/abl_seq.sv -----
`timescale 1ns / 1ps

module abl_seq
    import abl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    input  cfg_t  cfg,
    output logic  res_valid,
    input  logic  res_ready,
    output res_t  res
);

    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_IW = $clog2(DEPTH + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEPTH - 1);
    localparam logic [CNT_IW-1:0] FULL_CNT  = CNT_IW'(DEPTH);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_LOOK   = 5'b00010,
        S_INSERT = 5'b00100,
        S_EXPIRE = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == LAST_SLOT) ? '0 : SLOT_W'(s + 1'b1);
    endfunction

    // control state
    state_t            state_reg,    state_next;
    logic [SLOT_W-1:0] oldest_reg,   oldest_next;
    logic [SLOT_W-1:0] tail_reg,     tail_next;
    logic [CNT_IW-1:0] held_reg,     held_next;
    logic              rd_valid_reg, rd_valid_next;

    // per item work registers
    logic [IP_W-1:0]   ip_reg,       ip_next;
    logic [TIME_W-1:0] now_reg,      now_next;
    status_t           status_reg,   status_next;
    logic              evict_reg,    evict_next;
    logic [IP_W-1:0]   evict_ip_reg, evict_ip_next;
    logic [CNT_IW-1:0] expired_reg,  expired_next;
    logic [CNT_IW-1:0] iss_cnt_reg,  iss_cnt_next;
    logic [CNT_IW-1:0] lim_reg,      lim_next;
    logic [SLOT_W-1:0] rd_slot_reg,  rd_slot_next;
    logic              first_reg,    first_next;

    logic              issue;
    logic              finish;
    logic              wr_en;
    logic [IP_W-1:0]   addr_rdata;
    logic [TIME_W-1:0] time_rdata;
    cmp_mode_t         cmp_mode;
    logic [IP_W-1:0]   cmp_data;
    logic [IP_W-1:0]   cmp_key;
    logic              hit;

    abl_ram #(.WIDTH(IP_W), .DEPTH(DEPTH)) u_addr_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data (ip_reg),
        .rd_en   (issue),
        .rd_addr (rd_slot_reg),
        .rd_data (addr_rdata)
    );

    abl_ram #(.WIDTH(TIME_W), .DEPTH(DEPTH)) u_time_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data (now_reg),
        .rd_en   (issue),
        .rd_addr (rd_slot_reg),
        .rd_data (time_rdata)
    );

    // one compare unit serves both the lookup and the expiry walk
    assign cmp_mode = (state_reg == S_EXPIRE) ? CMP_AGE : CMP_EQ;
    assign cmp_data = (state_reg == S_EXPIRE) ? time_rdata : addr_rdata;
    assign cmp_key  = (state_reg == S_EXPIRE) ? now_reg : ip_reg;

    abl_cmp u_cmp (
        .mode  (cmp_mode),
        .data  (cmp_data),
        .key   (cmp_key),
        .limit (cfg.hold_seconds),
        .hit   (hit)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    always_comb begin
        state_next    = state_reg;
        oldest_next   = oldest_reg;
        tail_next     = tail_reg;
        held_next     = held_reg;
        rd_valid_next = 1'b0;
        ip_next       = ip_reg;
        now_next      = now_reg;
        status_next   = status_reg;
        evict_next    = evict_reg;
        evict_ip_next = evict_ip_reg;
        expired_next  = expired_reg;
        iss_cnt_next  = iss_cnt_reg;
        lim_next      = lim_reg;
        rd_slot_next  = rd_slot_reg;
        first_next    = first_reg;
        issue         = 1'b0;
        finish        = 1'b0;
        wr_en         = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    ip_next      = in_item.src_ip;
                    now_next     = in_item.now_seconds;
                    evict_next   = 1'b0;
                    expired_next = '0;
                    rd_slot_next = oldest_reg;
                    iss_cnt_next = '0;
                    lim_next     = held_reg;
                    first_next   = 1'b1;
                    if (in_item.src_ip == '0) begin
                        status_next = ST_ZERO;
                        state_next  = S_DONE;
                    end else if (in_item.src_ip[IP_W-1:IP_W-PREFIX_W] ==
                                 cfg.local_prefix) begin
                        status_next = ST_LOCAL;
                        state_next  = S_DONE;
                    end else begin
                        state_next = S_LOOK;
                    end
                end
            end

            S_LOOK: begin
                // one read issued per cycle, compared in the next cycle
                issue = (iss_cnt_reg < lim_reg);
                if (issue) begin
                    rd_slot_next = slot_inc(rd_slot_reg);
                    iss_cnt_next = CNT_IW'(iss_cnt_reg + 1'b1);
                end
                rd_valid_next = issue;
                if (rd_valid_reg) begin
                    first_next = 1'b0;
                    // the first entry read is the oldest, kept for eviction
                    if (first_reg) begin
                        evict_ip_next = addr_rdata;
                    end
                end
                if (rd_valid_reg && hit) begin
                    status_next   = ST_HELD;
                    state_next    = S_DONE;
                    rd_valid_next = 1'b0;
                end else if (!issue && !rd_valid_reg) begin
                    status_next = ST_NEW;
                    state_next  = S_INSERT;
                end
            end

            S_INSERT: begin
                wr_en     = 1'b1;
                tail_next = slot_inc(tail_reg);
                if (held_reg == FULL_CNT) begin
                    evict_next   = 1'b1;
                    oldest_next  = slot_inc(oldest_reg);
                    rd_slot_next = slot_inc(oldest_reg);
                end else begin
                    held_next    = CNT_IW'(held_reg + 1'b1);
                    rd_slot_next = oldest_reg;
                end
                lim_next     = held_next;
                iss_cnt_next = '0;
                state_next   = S_EXPIRE;
            end

            S_EXPIRE: begin
                issue = (iss_cnt_reg < lim_reg);
                if (issue) begin
                    rd_slot_next = slot_inc(rd_slot_reg);
                    iss_cnt_next = CNT_IW'(iss_cnt_reg + 1'b1);
                end
                rd_valid_next = issue;
                if (rd_valid_reg) begin
                    if (hit) begin
                        oldest_next  = slot_inc(oldest_reg);
                        held_next    = CNT_IW'(held_reg - 1'b1);
                        expired_next = CNT_IW'(expired_reg + 1'b1);
                        finish       = (held_next == '0);
                    end else begin
                        finish = 1'b1;
                    end
                end else if (!issue) begin
                    finish = 1'b1;
                end
                if (finish) begin
                    state_next    = S_DONE;
                    rd_valid_next = 1'b0;
                    if (held_next == '0) begin
                        oldest_next = '0;
                        tail_next   = '0;
                    end
                end
            end

            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            oldest_reg   <= '0;
            tail_reg     <= '0;
            held_reg     <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            oldest_reg   <= oldest_next;
            tail_reg     <= tail_next;
            held_reg     <= held_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ip_reg       <= ip_next;
        now_reg      <= now_next;
        status_reg   <= status_next;
        evict_reg    <= evict_next;
        evict_ip_reg <= evict_ip_next;
        expired_reg  <= expired_next;
        iss_cnt_reg  <= iss_cnt_next;
        lim_reg      <= lim_next;
        rd_slot_reg  <= rd_slot_next;
        first_reg    <= first_next;
    end

    always_comb begin
        res.status        = status_reg;
        res.block_ip      = (status_reg == ST_NEW) ? ip_reg : '0;
        res.evicted       = evict_reg;
        res.evicted_ip    = evict_reg ? evict_ip_reg : '0;
        res.expired_count = CNT_W'(expired_reg);
        res.entry_count   = CNT_W'(held_reg);
    end

`ifndef SYNTH
    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= FULL_CNT)
        else $error("held count above store depth");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> (state_reg != S_IDLE))
        else $error("accepted request did not start work");

    a_evict_only_new: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.evicted) |-> (res.status == ST_NEW))
        else $error("eviction without a new entry");

    a_empty_rewinds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && held_reg == '0) |-> (oldest_reg == '0 && tail_reg == '0))
        else $error("empty store not rewound to slot zero");
`endif

endmodule
